// ----- rtl/dtti_pkg.sv -----
// ----------------------------------------------------------------------------
// dtti_pkg
// Shared types and constants for the decimal text to int64 parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dtti_pkg;

  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_SIGN  = 3'd1,
    PH_DIGIT = 3'd2,
    PH_TRAIL = 3'd3
  } scan_phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTINT   = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_TRAILING = 2'd3
  } parse_status_t;

  localparam int unsigned ValueW = 64;
  localparam int unsigned ProdW  = ValueW + 4;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

endpackage

`default_nettype wire

// ----- rtl/decimal_text_to_int64.sv -----
// ----------------------------------------------------------------------------
// decimal_text_to_int64
// Streams text one byte per word and returns one signed 64-bit value and a
// status word when the string ends.
// ----------------------------------------------------------------------------
// Path: the accepted word with tlast passes the input register, then the result
//   register, before the result word is valid.
// Throughput: one input word per cycle unless a tlast word stalls on the result;
//   the digit step (times ten plus digit and range check) works off the input register.
// Reset: synchronous, active low; clears scan state and both valid flags.
`default_nettype none

module decimal_text_to_int64 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] text_byte
  input  wire logic        in_tuser,   // [0] byte_present
  input  wire logic        in_tlast,   // end_of_text
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [63:0] parsed_value
  output logic [1:0]       out_tuser   // [1:0] parse_status
);
  import dtti_pkg::*;

  logic                 s1_valid_r;
  logic [7:0]           s1_byte_r;
  logic                 s1_present_r;
  logic                 s1_last_r;

  scan_phase_t          phase_r, phase_nxt;
  logic                 neg_r, neg_nxt;
  logic [ValueW-1:0]    acc_r, acc_nxt;
  parse_status_t        err_r, err_nxt;

  logic                 out_valid_r;
  logic [ValueW-1:0]    out_value_r;
  parse_status_t        out_status_r;

  logic                 out_free;
  logic                 advance;
  logic                 is_ws;
  logic                 is_digit;
  logic [3:0]           digit;
  logic [ProdW-1:0]     acc_ext;
  logic [ProdW-1:0]     times10;
  logic [ProdW-1:0]     digit_ext;
  logic [ProdW-1:0]     prod;
  logic                 fits;
  parse_status_t        res_status;
  logic [ValueW-1:0]    res_value;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || advance;

  assign is_ws = (s1_byte_r inside {ChSpace, ChTab, ChLf, ChVt, ChFf, ChCr});
  assign is_digit = (s1_byte_r inside {[ChZero:ChNine]});
  assign digit = 4'(s1_byte_r - ChZero);

  // accumulator holds the signed value: +magnitude or -magnitude
  assign acc_ext   = {{(ProdW-ValueW){acc_r[ValueW-1]}}, acc_r};
  assign times10   = (acc_ext << 3) + (acc_ext << 1);
  assign digit_ext = {{(ProdW-4){1'b0}}, digit};
  assign prod      = neg_r ? (times10 - digit_ext) : (times10 + digit_ext);
  assign fits      = (prod[ProdW-1:ValueW-1] == '0) || (prod[ProdW-1:ValueW-1] == '1);

  // next scan state for one byte
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    err_nxt   = err_r;
    if (s1_present_r && (err_r == ST_OK)) begin
      case (phase_r)
        PH_LEAD: begin
          if (is_ws) begin
            phase_nxt = PH_LEAD;
          end else if ((s1_byte_r == ChPlus) || (s1_byte_r == ChMinus)) begin
            neg_nxt   = (s1_byte_r == ChMinus);
            phase_nxt = PH_SIGN;
          end else if (is_digit) begin
            if (fits) begin
              acc_nxt   = prod[ValueW-1:0];
              phase_nxt = PH_DIGIT;
            end else begin
              err_nxt = ST_OVERFLOW;
            end
          end else begin
            err_nxt = ST_NOTINT;
          end
        end
        PH_SIGN: begin
          if (is_digit) begin
            if (fits) begin
              acc_nxt   = prod[ValueW-1:0];
              phase_nxt = PH_DIGIT;
            end else begin
              err_nxt = ST_OVERFLOW;
            end
          end else begin
            err_nxt = ST_NOTINT;
          end
        end
        PH_DIGIT: begin
          if (is_digit) begin
            if (fits) begin
              acc_nxt = prod[ValueW-1:0];
            end else begin
              err_nxt = ST_OVERFLOW;
            end
          end else if (is_ws) begin
            phase_nxt = PH_TRAIL;
          end else begin
            err_nxt = ST_TRAILING;
          end
        end
        default: begin
          if (!is_ws) begin
            err_nxt = ST_TRAILING;
          end
        end
      endcase
    end
  end

  // result for a word that ends the string
  always_comb begin
    res_status = err_nxt;
    if ((err_nxt == ST_OK) && ((phase_nxt == PH_LEAD) || (phase_nxt == PH_SIGN))) begin
      res_status = ST_NOTINT;
    end
    res_value = (res_status == ST_OK) ? acc_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      phase_r     <= PH_LEAD;
      neg_r       <= 1'b0;
      acc_r       <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        if (s1_last_r) begin
          phase_r <= PH_LEAD;
          neg_r   <= 1'b0;
          acc_r   <= '0;
          err_r   <= ST_OK;
        end else begin
          phase_r <= phase_nxt;
          neg_r   <= neg_nxt;
          acc_r   <= acc_nxt;
          err_r   <= err_nxt;
        end
      end
      if (advance && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r    <= in_tdata;
      s1_present_r <= in_tuser;
      s1_last_r    <= in_tlast;
    end
    if (advance && s1_last_r) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire

// ----- rtl/dtti_chk.sv -----
// ----------------------------------------------------------------------------
// dtti_chk
// Port-level checks for decimal_text_to_int64, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dtti_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic [1:0]  out_tuser
);
  import dtti_pkg::*;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // drop the value on any error status
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> (out_tdata == 64'd0))
    else $error("nonzero value with error status");

  // clear the result side on reset
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a result only appears after a word with tlast went in
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 2) ||
                          $past(!in_tready, 1))
    else $error("result without an ending word");

endmodule

bind decimal_text_to_int64 dtti_chk u_dtti_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
